// ----- design/tcif_pkg.sv -----
// Shared types, constants and helpers for the three-channel IIR filter unit.
// No dependencies; imported by every module in the design folder.
package tcif_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int ORDER     = 10;
    localparam int NUM_CH    = 3;
    localparam int DIV_SHIFT = 8;
    localparam int COEF_W    = 8;
    // 553 * 2^31 bounds every partial sum; 12 guard bits cover it
    localparam int ACC_W     = SAMPLE_W + 12;
    localparam int DATA_W    = NUM_CH * SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    localparam coef_t NUM_TAPS [0:ORDER] = '{
        8'sd12, 8'sd0, -8'sd60, 8'sd0, 8'sd120, 8'sd0, -8'sd120, 8'sd0, 8'sd60, 8'sd0, -8'sd12
    };

    localparam coef_t DEN_TAPS [0:ORDER] = '{
        8'sd64, -8'sd70, 8'sd30, -8'sd16, 8'sd29, -8'sd17, 8'sd5, -8'sd1, 8'sd1, 8'sd0, 8'sd0
    };

    // clamp a wide signed value to the sample range
    function automatic sample_t sat_sample(acc_t v);
        logic [ACC_W-SAMPLE_W:0] upper;
        sample_t                 r;
        upper = v[ACC_W-1:SAMPLE_W-1];
        if ((&upper) || !(|upper)) begin
            r = v[SAMPLE_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- design/tcif_cell.sv -----
// One tap cell of the transposed filter chain: holds one partial sum.
// Depends on tcif_pkg.
module tcif_cell
    import tcif_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  coef_t   num_coef,
    input  coef_t   den_coef,
    input  sample_t x,
    input  sample_t y,
    input  acc_t    sum_in,
    output acc_t    sum_out
);

    acc_t sum_reg;
    acc_t sum_next;

    assign sum_next = acc_t'(acc_t'(x) * acc_t'(num_coef))
                    - acc_t'(acc_t'(y) * acc_t'(den_coef))
                    + sum_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

// ----- design/tcif_channel.sv -----
// One filter channel: a row of tap cells plus the head tap, divide and clamp.
// Depends on tcif_pkg and tcif_cell.
module tcif_channel
    import tcif_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  sample_t x,
    output sample_t y
);

    acc_t    sums [1:ORDER+1];
    acc_t    acc;
    acc_t    shifted;
    sample_t y_int;

    assign sums[ORDER+1] = '0;

    for (genvar k = 1; k <= ORDER; k++) begin : g_cell
        tcif_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .num_coef (NUM_TAPS[k]),
            .den_coef (DEN_TAPS[k]),
            .x        (x),
            .y        (y_int),
            .sum_in   (sums[k+1]),
            .sum_out  (sums[k])
        );
    end

    assign acc     = acc_t'(acc_t'(x) * acc_t'(NUM_TAPS[0])) + sums[1];
    assign shifted = acc >>> DIV_SHIFT;
    assign y_int   = sat_sample(shifted);
    assign y       = y_int;

endmodule

// ----- design/three_channel_iir_filter_unit.sv -----
// Three-channel 10th-order transposed-form IIR filter unit, top level.
// Depends on tcif_pkg and tcif_channel.
//
// Filters x shift, y shift and angle (signed Q16.16) with fixed integer taps,
// divides by 256 with floor rounding and clamps to 32 bits. One transfer is
// taken per cycle unless an unread result blocks it; each result is in the
// output register next cycle. Each channel keeps its history as a row of ten
// partial sums (transposed form), so the loop per item is one constant
// multiply-add through the head tap and clamp. All history is zero after reset.
module three_channel_iir_filter_unit
    import tcif_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // in_dx, in_dy, in_angle
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata    // out_dx, out_dy, out_angle
);

    logic              accept;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg;
    logic [DATA_W-1:0] m_tdata_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        sample_t y_ch;

        tcif_channel u_channel (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (accept),
            .x       (sample_t'(s_tdata[c*SAMPLE_W +: SAMPLE_W])),
            .y       (y_ch)
        );

        assign m_tdata_next[c*SAMPLE_W +: SAMPLE_W] = y_ch;
    end

    assign m_tvalid_next = accept || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- tb/tcif_motion_checker.sv -----
// Checker for three_channel_iir_filter_unit: watches both stream channels, runs its own
// three-channel direct-form-I filter on every input transfer and compares results in order.
// Depends on tcif_pkg for widths and the sample type.
module tcif_motion_checker
    import tcif_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    output int                n_errors,
    output int                n_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TAPS_N    = 10;
    localparam int     GAIN_SHFT = 8;
    localparam longint SAT_HI    = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_LO    = -SAT_HI - 1;

    localparam longint FWD_COEF [0:TAPS_N] = '{12, 0, -60, 0, 120, 0, -120, 0, 60, 0, -12};
    localparam longint FBK_COEF [0:TAPS_N] = '{64, -70, 30, -16, 29, -17, 5, -1, 1, 0, 0};

    typedef struct packed {
        sample_t angle;
        sample_t dy;
        sample_t dx;
    } motion_t;

    sample_t x_hist [NUM_CH][TAPS_N];
    sample_t y_hist [NUM_CH][TAPS_N];
    motion_t filtered_q [$];
    int      errs;
    int      taken;
    int      given;

    assign n_errors  = errs;
    assign n_waiting = taken - given;

    function automatic sample_t filter_channel(int ch, sample_t x);
        longint acc;
        longint q;
        sample_t y;
        acc = FWD_COEF[0] * longint'(x);
        for (int n = 1; n <= TAPS_N; n++) begin
            acc += FWD_COEF[n] * longint'(x_hist[ch][n-1])
                 - FBK_COEF[n] * longint'(y_hist[ch][n-1]);
        end
        q = acc >>> GAIN_SHFT;
        if (q > SAT_HI) begin
            y = sample_t'(SAT_HI);
        end else if (q < SAT_LO) begin
            y = sample_t'(SAT_LO);
        end else begin
            y = sample_t'(q);
        end
        for (int n = TAPS_N - 1; n > 0; n--) begin
            x_hist[ch][n] = x_hist[ch][n-1];
            y_hist[ch][n] = y_hist[ch][n-1];
        end
        x_hist[ch][0] = x;
        y_hist[ch][0] = y;
        return y;
    endfunction

    function automatic motion_t filter_motion(motion_t s);
        motion_t r;
        r.dx    = filter_channel(0, s.dx);
        r.dy    = filter_channel(1, s.dy);
        r.angle = filter_channel(2, s.angle);
        return r;
    endfunction

    always @(posedge aclk) begin
        motion_t got;
        motion_t want;
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                for (int n = 0; n < TAPS_N; n++) begin
                    x_hist[c][n] = '0;
                    y_hist[c][n] = '0;
                end
            end
            filtered_q.delete();
            errs  = 0;
            taken = 0;
            given = 0;
        end else begin
            // pop before push: a result never belongs to the input of the same edge
            if (m_tvalid && m_tready) begin
                got = motion_t'(m_tdata);
                if (filtered_q.size() == 0) begin
                    $error("unexpected result transfer: %h", m_tdata);
                    errs++;
                end else begin
                    want = filtered_q.pop_front();
                    given++;
                    if (got.dx !== want.dx) begin
                        $error("out_dx: expected %0d, got %0d", want.dx, got.dx);
                        errs++;
                    end
                    if (got.dy !== want.dy) begin
                        $error("out_dy: expected %0d, got %0d", want.dy, got.dy);
                        errs++;
                    end
                    if (got.angle !== want.angle) begin
                        $error("out_angle: expected %0d, got %0d", want.angle, got.angle);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                filtered_q.push_back(filter_motion(motion_t'(s_tdata)));
                taken++;
            end
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top-level bench for three_channel_iir_filter_unit: drives directed then random motion
// samples under varying backpressure, and gives the verdict from tcif_motion_checker.
// Depends on tcif_pkg, the filter unit and tb/tcif_motion_checker.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcif_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 445;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;

    int      n_errors;
    int      n_waiting;
    int      src_idle_pct = 0;
    int      snk_idle_pct = 0;
    int      cycles       = 0;
    sample_t tone_amp     = 32'sh4000_0000;

    three_channel_iir_filter_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tcif_motion_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_errors  (n_errors),
        .n_waiting (n_waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_motion(input sample_t dx, input sample_t dy, input sample_t angle);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {angle, dy, dx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // quarter-rate tone sits on the numerator peak and drives the outputs into the clamp
    function automatic sample_t pick_sample(int k);
        case ($urandom_range(9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5:       return sample_t'($urandom_range(2000) - 1000);
            6: begin
                case ($urandom_range(4))
                    0:       return 32'sh7fff_ffff;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sh0000_0000;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: begin
                if (k[0]) return '0;
                return k[1] ? -tone_amp : tone_amp;
            end
        endcase
    endfunction

    task automatic run_random(input int src_pct, input int snk_pct, input int n);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < n; k++) begin
            if (k % 64 == 0) tone_amp = sample_t'($urandom_range(32'h7fff_ffff));
            send_motion(pick_sample(k), pick_sample(k + 1), pick_sample(k + 2));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 35;
        snk_idle_pct = 52;
        send_motion('0, '0, '0);
        send_motion(32'sh7fff_ffff, 32'sh8000_0000, 32'sd1);
        send_motion(32'sh8000_0000, 32'sh7fff_ffff, -32'sd1);
        send_motion(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0001_0000);
        send_motion(32'shaaaa_aaaa, 32'sh5555_5555, -32'sh0001_0000);
        send_motion(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        repeat (4) send_motion('0, '0, '0);
        // quarter-rate full-scale tone, opposite phase on dy, to force saturation
        for (int k = 0; k < 14; k++) begin
            case (k % 4)
                0:       send_motion(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
                2:       send_motion(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
                default: send_motion('0, '0, '0);
            endcase
        end

        run_random(35, 52, PHASE_ITEMS);
        run_random(52, 35, PHASE_ITEMS);
        run_random(0, 0, PHASE_ITEMS);
        s_tvalid <= 1'b0;

        while (n_waiting != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
